/* hw/rtl/sgsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgsc_pkg
// Shared types and constants for the sparse grid support counter.
// ----------------------------------------------------------------------------
package sgsc_pkg;
	localparam int MAX_CAND_DEF   = 64;
	localparam int DIMS_DEF       = 4;
	localparam int COORD_BITS_DEF = 16;
	localparam int COORD_FIELDS   = 4;
	localparam int LEVEL_W        = 5;
	localparam int INDEX_W        = 16;
	localparam int SLOT_W         = 6;
	localparam int DSEL_W         = 2;
	localparam int MINSUP_W       = 16;
	localparam int CCOUNT_W       = 7;
	localparam int ADIMS_W        = 3;
	localparam int COUNT_W        = 17;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_POINT  = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SUP_THRESH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAND_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS = 2'd2;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0] index;
	} cand_entry_t;
endpackage
`default_nettype wire

/* hw/rtl/sgsc_box_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgsc_box_lane
// Tests one coordinate against one candidate's open box in one dimension.
// ----------------------------------------------------------------------------
module sgsc_box_lane #(
	parameter int COORD_BITS = sgsc_pkg::COORD_BITS_DEF
) (
	input  wire logic [COORD_BITS-1:0] coord,
	input  wire sgsc_pkg::cand_entry_t entry,
	output logic                       hit
);
	import sgsc_pkg::*;
	localparam int SW = COORD_BITS + 32;
	logic [SW-1:0] scaled;
	logic [SW-1:0] lo_b;
	logic [SW-1:0] hi_b;
	logic [INDEX_W:0] idx_p1;
	always_comb begin
		scaled = SW'(coord) << entry.level;
		idx_p1 = {1'b0, entry.index} + (INDEX_W+1)'(1);
		lo_b   = SW'(entry.index - INDEX_W'(1)) << COORD_BITS;
		hi_b   = SW'(idx_p1) << COORD_BITS;
		hit    = ((entry.index == '0) || (scaled > lo_b)) && (scaled < hi_b);
	end
endmodule
`default_nettype wire

/* hw/rtl/sparse_grid_support_counter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_grid_support_counter
// Counts data points inside the support boxes of loaded sparse-grid candidates.
// ----------------------------------------------------------------------------
// Input transactions carry a command. A load writes one level/index pair of the
// candidate table. A data point walks the candidates one per cycle, the active
// dimensions tested in parallel lanes against the table row read from the
// candidate memory, with each counter read and written back one stage later. A
// report reads the counters through a registered stage and emits one output
// transaction per candidate slot, one per cycle while the receiver takes them.
// The first result passes the counter read stage and the output register after
// the command is accepted. A stalled receiver holds the current result and the
// walk. The counters are cleared once the last result is taken. A report or a
// point with a candidate count of zero stays in idle; such a report only clears
// the counters. The next input transaction is taken once the previous command
// has finished. Configuration writes go through the separate cfg channel and
// are always ready. Reset clears the per-slot valid bits so that every counter
// reads zero, and sets the support threshold to 0, candidate_count to 0 and
// active_dims to 4. The candidate table is undefined until loaded.
// ----------------------------------------------------------------------------
module sparse_grid_support_counter #(
	parameter int MAX_CANDIDATES = sgsc_pkg::MAX_CAND_DEF,
	parameter int DIMS           = sgsc_pkg::DIMS_DEF,
	parameter int COORD_BITS     = sgsc_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sgsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sgsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              valid,
	output logic                                   ready,
	input  wire logic [1:0]                        cmd,
	input  wire logic [sgsc_pkg::SLOT_W-1:0]       slot,
	input  wire logic [sgsc_pkg::DSEL_W-1:0]       dim_select,
	input  wire logic [sgsc_pkg::LEVEL_W-1:0]      level,
	input  wire logic [sgsc_pkg::INDEX_W-1:0]      grid_index,
	input  wire logic [COORD_BITS-1:0]             coord_0,
	input  wire logic [COORD_BITS-1:0]             coord_1,
	input  wire logic [COORD_BITS-1:0]             coord_2,
	input  wire logic [COORD_BITS-1:0]             coord_3,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [sgsc_pkg::SLOT_W-1:0]            result_slot,
	output logic [sgsc_pkg::COUNT_W-1:0]           support_count,
	output logic                                   supported,
	output logic                                   last
);
	import sgsc_pkg::*;

	localparam int CW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int NW   = $clog2(MAX_CANDIDATES + 1);
	localparam int LIM  = (DIMS < COORD_FIELDS) ? DIMS : COORD_FIELDS;

	typedef enum logic [1:0] {ST_IDLE, ST_POINT, ST_REPORT} state_t;

	state_t                  state_q;
	logic [MINSUP_W-1:0]     sup_thresh_q;
	logic [CCOUNT_W-1:0]     cand_count_q;
	logic [ADIMS_W-1:0]      active_dims_q;
	logic [CW-1:0]           rd_ptr_q;
	logic [NW-1:0]           nc_q;
	logic                    rd_done_q;
	logic                    v_s1;
	logic [CW-1:0]           c_s1;
	logic [COUNT_W-1:0]      cnt_s1;
	logic [COORD_BITS-1:0]   coord_q [LIM];
	cand_entry_t             mem_q [MAX_CANDIDATES][DIMS];
	cand_entry_t             row_s1 [DIMS];
	logic [COUNT_W-1:0]      cnt_mem_q [MAX_CANDIDATES];
	logic [MAX_CANDIDATES-1:0] cnt_vld_q;
	logic [LIM-1:0]          lane_hit;
	logic [ADIMS_W-1:0]      nd;
	logic [NW-1:0]           nc;
	logic                    row_hit;
	logic                    acc;
	logic                    out_ld;
	logic                    s1_take;
	logic                    cnt_we;

	assign cfg_ready = 1'b1;
	assign ready     = (state_q == ST_IDLE);
	assign acc       = valid && ready;

	always_comb begin
		if (active_dims_q == '0) nd = ADIMS_W'(1);
		else if (active_dims_q > ADIMS_W'(LIM)) nd = ADIMS_W'(LIM);
		else nd = active_dims_q;
		if (cand_count_q > CCOUNT_W'(MAX_CANDIDATES)) nc = NW'(MAX_CANDIDATES);
		else nc = NW'(cand_count_q);
	end

	for (genvar d = 0; d < LIM; d++) begin : g_lane
		logic h;
		sgsc_box_lane #(.COORD_BITS(COORD_BITS)) u_lane (
			.coord(coord_q[d]), .entry(row_s1[d]), .hit(h)
		);
		assign lane_hit[d] = h || (ADIMS_W'(d) >= nd);
	end
	assign row_hit = &lane_hit;

	assign out_ld  = (state_q == ST_REPORT) && v_s1 && (!out_valid || out_ready);
	assign s1_take = (state_q == ST_POINT) || ((state_q == ST_REPORT) && (!v_s1 || out_ld));
	assign cnt_we  = (state_q == ST_POINT) && v_s1 && row_hit
		&& (cnt_s1 <= COUNT_W'(sup_thresh_q));

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_LOAD && 32'(slot) < MAX_CANDIDATES
				&& 32'(dim_select) < DIMS) begin
			mem_q[CW'(slot)][dim_select] <= '{level: level, index: grid_index};
		end
		for (int d = 0; d < DIMS; d++) row_s1[d] <= mem_q[rd_ptr_q][d];
		if (s1_take) cnt_s1 <= cnt_vld_q[rd_ptr_q] ? cnt_mem_q[rd_ptr_q] : '0;
		if (cnt_we) cnt_mem_q[c_s1] <= cnt_s1 + COUNT_W'(1);
		if (acc) begin
			coord_q[0] <= coord_0;
			if (LIM > 1) coord_q[LIM > 1 ? 1 : 0] <= coord_1;
			if (LIM > 2) coord_q[LIM > 2 ? 2 : 0] <= coord_2;
			if (LIM > 3) coord_q[LIM > 3 ? 3 : 0] <= coord_3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sup_thresh_q  <= '0;
			cand_count_q  <= '0;
			active_dims_q <= ADIMS_W'(4);
			rd_ptr_q      <= '0;
			nc_q          <= '0;
			rd_done_q     <= 1'b0;
			v_s1          <= 1'b0;
			c_s1          <= '0;
			out_valid     <= 1'b0;
			result_slot   <= '0;
			support_count <= '0;
			supported     <= 1'b0;
			last          <= 1'b0;
			cnt_vld_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SUP_THRESH:  sup_thresh_q  <= cfg_data;
					REG_CAND_COUNT:  cand_count_q  <= cfg_data[CCOUNT_W-1:0];
					REG_ACTIVE_DIMS: active_dims_q <= cfg_data[ADIMS_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					rd_ptr_q  <= '0;
					rd_done_q <= 1'b0;
					v_s1      <= 1'b0;
					nc_q      <= nc;
					if (acc && cmd == CMD_POINT && nc != '0) begin
						state_q <= ST_POINT;
					end else if (acc && cmd == CMD_REPORT) begin
						if (nc == '0) begin
							cnt_vld_q <= '0;
						end else begin
							state_q <= ST_REPORT;
						end
					end
				end
				ST_POINT: begin
					v_s1 <= !rd_done_q;
					c_s1 <= rd_ptr_q;
					if (!rd_done_q) begin
						if (NW'(rd_ptr_q) + NW'(1) == nc_q) rd_done_q <= 1'b1;
						else rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (cnt_we) cnt_vld_q[c_s1] <= 1'b1;
					if (v_s1 && rd_done_q) state_q <= ST_IDLE;
				end
				ST_REPORT: begin
					if (s1_take) begin
						v_s1 <= !rd_done_q;
						c_s1 <= rd_ptr_q;
						if (!rd_done_q) begin
							if (NW'(rd_ptr_q) + NW'(1) == nc_q) rd_done_q <= 1'b1;
							else rd_ptr_q <= rd_ptr_q + CW'(1);
						end
					end
					if (out_ld) begin
						out_valid     <= 1'b1;
						result_slot   <= SLOT_W'(c_s1);
						support_count <= cnt_s1;
						supported     <= cnt_s1 >= COUNT_W'(sup_thresh_q);
						last          <= NW'(c_s1) + NW'(1) == nc_q;
					end else if (out_valid && out_ready) begin
						out_valid <= 1'b0;
					end
					if (rd_done_q && !v_s1 && (!out_valid || out_ready)) begin
						state_q   <= ST_IDLE;
						cnt_vld_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_REPORT) else $error("result outside report");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !ready) else $error("accepted while busy");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_slot))
		else $error("result dropped under stall");
endmodule
`default_nettype wire
